FILE: hw/rtl/reno_cw_pkg.sv
`default_nettype none

package reno_cw_pkg;

    typedef enum logic [1:0] {
        PH_SLOW  = 2'd0,
        PH_AVOID = 2'd1,
        PH_RECOV = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        OP_BYTES_ACKED  = 3'd0,
        OP_LOSS         = 3'd1,
        OP_ECN          = 3'd2,
        OP_PACKET_SENT  = 3'd3,
        OP_PACKET_ACKED = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        REG_INITIAL_WINDOW = 2'd0,
        REG_SEGMENT_SIZE   = 2'd1,
        REG_MINIMUM_WINDOW = 2'd2
    } reg_index_t;

    localparam logic [31:0] INITIAL_WINDOW_RESET = 32'd12000;
    localparam logic [15:0] SEGMENT_SIZE_RESET   = 16'd1200;
    localparam logic [31:0] MINIMUM_WINDOW_RESET = 32'd2400;

endpackage

`default_nettype wire

FILE: hw/rtl/reno_congestion_window.sv
// A result appears on the master side in the cycle after its event is taken.
// One event per cycle while the output drains; each event updates the controller state in one pass.
// A new event is taken while the previous result waits, as long as the output is drained.
// Reset (rst_n low, asynchronous) restores slow start, the initial window of 12000 bytes,
// an all-ones threshold, zero in flight and the register defaults.
`default_nettype none

module reno_congestion_window
    import reno_cw_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // Fields from bit 0: byte_count[31:0], packet_number[93:32], zero fill.
    input  wire logic [95:0]  s_axis_tdata,
    // Fields from bit 0: opcode[2:0].
    input  wire logic [2:0]   s_axis_tuser,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // Fields from bit 0: available_window[31:0], window_now[63:32],
    // threshold_now[95:64], phase_now[97:96], zero fill.
    output logic [103:0]      m_axis_tdata,

    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
        end
    endfunction

    logic [15:0] segment_size_reg;
    logic [31:0] minimum_window_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] window_reg, window_next;
    logic [31:0] threshold_reg, threshold_next;
    logic [31:0] in_flight_reg, in_flight_next;
    logic [31:0] acc_reg, acc_next;
    logic [61:0] recovery_packet_reg, recovery_packet_next;

    logic        out_valid_reg;
    logic [31:0] avail_reg, avail_next;
    logic [31:0] out_window_reg;
    logic [31:0] out_threshold_reg;
    logic [1:0]  out_phase_reg;

    logic        accept;
    opcode_t     opcode;
    logic [31:0] byte_count;
    logic [61:0] packet_number;

    logic [31:0] grown_window;
    logic [31:0] grown_acc;
    logic [31:0] half_window;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign opcode        = opcode_t'(s_axis_tuser);
    assign byte_count    = s_axis_tdata[31:0];
    assign packet_number = s_axis_tdata[93:32];

    always_comb
    begin
        phase_next           = phase_reg;
        window_next          = window_reg;
        threshold_next       = threshold_reg;
        in_flight_next       = in_flight_reg;
        acc_next             = acc_reg;
        recovery_packet_next = recovery_packet_reg;
        grown_window         = sat_add(window_reg, byte_count);
        grown_acc            = sat_add(acc_reg, byte_count);
        half_window          = {1'b0, window_reg[31:1]};

        unique case (opcode)
            OP_BYTES_ACKED:
            begin
                if (phase_reg == PH_SLOW)
                begin
                    window_next = grown_window;
                    if (grown_window >= threshold_reg)
                    begin
                        phase_next = PH_AVOID;
                        acc_next   = '0;
                    end
                end
                else if (phase_reg == PH_AVOID)
                begin
                    acc_next = grown_acc;
                    if (grown_acc >= window_reg)
                    begin
                        window_next = sat_add(window_reg, {16'd0, segment_size_reg});
                        acc_next    = grown_acc - window_reg;
                    end
                end
            end
            OP_LOSS, OP_ECN:
            begin
                if (!(phase_reg == PH_RECOV && packet_number <= recovery_packet_reg))
                begin
                    threshold_next = (half_window < minimum_window_reg) ?
                                     minimum_window_reg : half_window;
                    window_next          = threshold_next;
                    phase_next           = PH_RECOV;
                    recovery_packet_next = packet_number;
                    acc_next             = '0;
                end
            end
            OP_PACKET_SENT:
            begin
                in_flight_next = sat_add(in_flight_reg, byte_count);
            end
            OP_PACKET_ACKED:
            begin
                in_flight_next = (in_flight_reg >= byte_count) ?
                                 in_flight_reg - byte_count : 32'd0;
                if (phase_reg == PH_RECOV && in_flight_next == 32'd0)
                begin
                    phase_next = PH_AVOID;
                    acc_next   = '0;
                end
            end
            default:
            begin
            end
        endcase

        avail_next = (in_flight_next >= window_next) ? 32'd0 : window_next - in_flight_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_size_reg   <= SEGMENT_SIZE_RESET;
            minimum_window_reg <= MINIMUM_WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEGMENT_SIZE:   segment_size_reg   <= cfg_wdata[15:0];
                REG_MINIMUM_WINDOW: minimum_window_reg <= cfg_wdata;
                // Writes to the initial window are ignored; it is only taken at reset, from its fixed default.
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_SLOW;
            window_reg          <= INITIAL_WINDOW_RESET;
            threshold_reg       <= 32'hFFFF_FFFF;
            in_flight_reg       <= '0;
            acc_reg             <= '0;
            recovery_packet_reg <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg           <= phase_next;
                window_reg          <= window_next;
                threshold_reg       <= threshold_next;
                in_flight_reg       <= in_flight_next;
                acc_reg             <= acc_next;
                recovery_packet_reg <= recovery_packet_next;
                out_valid_reg       <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            avail_reg         <= avail_next;
            out_window_reg    <= window_next;
            out_threshold_reg <= threshold_next;
            out_phase_reg     <= phase_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_phase_reg, out_threshold_reg, out_window_reg, avail_reg};

endmodule

`default_nettype wire
